>>> rtl/assert_macros.svh
// Assertion macros for the chunked body decoder RTL, included by its top level.
// Plain concurrent assertions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/hcbd_pkg.sv
// Types, constants and helper functions of the chunked body decoder.
// No dependencies; imported by every module of the block.
package hcbd_pkg;

   localparam logic [7:0]  CHAR_CR   = 8'h0D;
   localparam logic [7:0]  CHAR_LF   = 8'h0A;
   localparam logic [7:0]  CHAR_SEMI = 8'h3B;
   localparam logic [7:0]  CHAR_NUL  = 8'h00;
   localparam logic [13:0] ACC_MAX   = 14'h3FFF;

   localparam logic [13:0] TOTAL_LIMIT_RST = 14'd8192;
   localparam logic [9:0]  BODY_LIMIT_RST  = 10'd511;
   localparam logic [4:0]  LINE_MAX_RST    = 5'd31;

   typedef enum logic [1:0] {
      CSR_TOTAL_LIMIT = 2'd0,
      CSR_BODY_LIMIT  = 2'd1,
      CSR_LINE_MAX    = 2'd2
   } hcbd_csr_type;

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_DATA    = 3'd1,
      PH_CR      = 3'd2,
      PH_LF      = 3'd3,
      PH_TRAILER = 3'd4,
      PH_DONE    = 3'd5
   } hcbd_phase_type;

   typedef enum logic [2:0] {
      SY_WS     = 3'd0,
      SY_ZERO   = 3'd1,
      SY_PREFIX = 3'd2,
      SY_DIGITS = 3'd3,
      SY_OK     = 3'd4,
      SY_BAD    = 3'd5
   } hcbd_syntax_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_ABORT       = 3'd1,
      ERR_LINE_LONG   = 3'd2,
      ERR_BAD_SIZE    = 3'd3,
      ERR_OVER_LIMIT  = 3'd4,
      ERR_NO_CRLF     = 3'd5,
      ERR_TRAILER_LONG = 3'd6,
      ERR_EMPTY_BODY  = 3'd7
   } hcbd_err_type;

   // Result data word, declared highest field first so that payload_byte
   // lands in the lowest bits.
   typedef struct packed {
      logic [9:0]   body_count;
      hcbd_err_type error_code;
      logic         success;
      logic         finished;
      logic         truncated;
      logic [7:0]   payload_byte;
   } hcbd_rsp_data_type;

   typedef struct packed {
      logic              payload_valid;
      hcbd_rsp_data_type data;
   } hcbd_result_type;

   // Returns {is_hex, value}.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Space, tab, vertical tab and form feed.
   function automatic logic is_blank(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C);
   endfunction

endpackage

>>> rtl/hcbd_core.sv
// Decoder state, configuration registers and the per-byte update logic.
// Depends on hcbd_pkg.
module hcbd_core
   import hcbd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [13:0]     csr_wdata,
   input  logic            step,
   input  logic            action,
   input  logic [7:0]      rx_byte,
   output hcbd_result_type result
);

   logic [13:0]     total_limit_ff;
   logic [9:0]      body_limit_ff;
   logic [4:0]      line_max_ff;

   hcbd_phase_type  phase_ff, phase_in;
   hcbd_syntax_type syntax_ff, syntax_in;
   logic [4:0]      line_chars_ff, line_chars_in;
   logic [13:0]     size_accum_ff, size_accum_in;
   logic [13:0]     remaining_ff, remaining_in;
   logic [13:0]     total_ff, total_in;
   logic [9:0]      delivered_ff, delivered_in;
   logic            trunc_ff, trunc_in;
   logic            success_ff, success_in;
   logic            ovf_ff, ovf_in;
   logic            crlf_bad_ff, crlf_bad_in;
   hcbd_err_type    err_ff, err_in;

   logic [4:0]      hex;
   logic            is_digit;
   logic            is_stop;
   logic            digit_ovf;
   logic [13:0]     accum_digit;
   logic [14:0]     total_sum;
   logic            over_limit;
   logic            pv;
   logic [7:0]      pb;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_limit_ff <= TOTAL_LIMIT_RST;
         body_limit_ff  <= BODY_LIMIT_RST;
         line_max_ff    <= LINE_MAX_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_LIMIT: total_limit_ff <= csr_wdata;
            CSR_BODY_LIMIT:  body_limit_ff  <= csr_wdata[9:0];
            CSR_LINE_MAX:    line_max_ff    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      hex         = hex_decode(rx_byte);
      is_digit    = hex[4];
      is_stop     = (rx_byte == CHAR_SEMI) || (rx_byte == CHAR_NUL);
      // Saturate once the accumulator would pass 14 bits.
      digit_ovf   = ovf_ff || (size_accum_ff[13:10] != 4'd0);
      accum_digit = digit_ovf ? ACC_MAX : {size_accum_ff[9:0], hex[3:0]};
      total_sum   = {1'b0, total_ff} + {1'b0, size_accum_ff};
      over_limit  = total_sum > {1'b0, total_limit_ff};
   end

   always_comb begin
      phase_in      = phase_ff;
      syntax_in     = syntax_ff;
      line_chars_in = line_chars_ff;
      size_accum_in = size_accum_ff;
      remaining_in  = remaining_ff;
      total_in      = total_ff;
      delivered_in  = delivered_ff;
      trunc_in      = trunc_ff;
      success_in    = success_ff;
      ovf_in        = ovf_ff;
      crlf_bad_in   = crlf_bad_ff;
      err_in        = err_ff;
      pv            = 1'b0;
      pb            = 8'h00;

      if (step && phase_ff != PH_DONE) begin
         if (action) begin
            phase_in = PH_DONE;
            err_in   = ERR_ABORT;
         end else begin
            unique case (phase_ff)
               PH_SIZE: begin
                  if (rx_byte == CHAR_CR) begin
                     phase_in = PH_SIZE;
                  end else if (rx_byte == CHAR_LF) begin
                     if (syntax_ff != SY_ZERO && syntax_ff != SY_DIGITS &&
                         syntax_ff != SY_OK) begin
                        phase_in = PH_DONE;
                        err_in   = ERR_BAD_SIZE;
                     end else if (size_accum_ff == 14'd0 && !ovf_ff) begin
                        line_chars_in = 5'd0;
                        phase_in      = PH_TRAILER;
                     end else if (ovf_ff || over_limit) begin
                        phase_in = PH_DONE;
                        err_in   = ERR_OVER_LIMIT;
                     end else begin
                        total_in     = total_sum[13:0];
                        remaining_in = size_accum_ff;
                        phase_in     = PH_DATA;
                     end
                  end else if (line_chars_ff >= line_max_ff) begin
                     phase_in = PH_DONE;
                     err_in   = ERR_LINE_LONG;
                  end else begin
                     line_chars_in = line_chars_ff + 5'd1;
                     unique case (syntax_ff)
                        SY_WS: begin
                           if (is_blank(rx_byte)) begin
                              syntax_in = SY_WS;
                           end else if (rx_byte == 8'h30) begin
                              syntax_in = SY_ZERO;
                           end else if (is_digit) begin
                              size_accum_in = accum_digit;
                              ovf_in        = digit_ovf;
                              syntax_in     = SY_DIGITS;
                           end else begin
                              syntax_in = SY_BAD;
                           end
                        end
                        SY_ZERO: begin
                           if (rx_byte == 8'h78 || rx_byte == 8'h58) begin
                              syntax_in = SY_PREFIX;
                           end else if (is_stop) begin
                              syntax_in = SY_OK;
                           end else if (is_digit) begin
                              size_accum_in = accum_digit;
                              ovf_in        = digit_ovf;
                              syntax_in     = SY_DIGITS;
                           end else begin
                              syntax_in = SY_BAD;
                           end
                        end
                        SY_PREFIX: begin
                           if (is_digit) begin
                              size_accum_in = accum_digit;
                              ovf_in        = digit_ovf;
                              syntax_in     = SY_DIGITS;
                           end else begin
                              syntax_in = SY_BAD;
                           end
                        end
                        SY_DIGITS: begin
                           if (is_digit) begin
                              size_accum_in = accum_digit;
                              ovf_in        = digit_ovf;
                           end else if (is_stop) begin
                              syntax_in = SY_OK;
                           end else begin
                              syntax_in = SY_BAD;
                           end
                        end
                        default: syntax_in = syntax_ff;
                     endcase
                  end
               end
               PH_DATA: begin
                  if (delivered_ff < body_limit_ff) begin
                     delivered_in = delivered_ff + 10'd1;
                     pv           = 1'b1;
                     pb           = rx_byte;
                  end else begin
                     trunc_in = 1'b1;
                  end
                  // A chunk in flight always holds at least one byte.
                  if (remaining_ff <= 14'd1) begin
                     remaining_in = 14'd0;
                     crlf_bad_in  = 1'b0;
                     phase_in     = PH_CR;
                  end else begin
                     remaining_in = remaining_ff - 14'd1;
                  end
               end
               PH_CR: begin
                  if (rx_byte != CHAR_CR) begin
                     crlf_bad_in = 1'b1;
                  end
                  phase_in = PH_LF;
               end
               PH_LF: begin
                  if (crlf_bad_ff || rx_byte != CHAR_LF) begin
                     phase_in = PH_DONE;
                     err_in   = ERR_NO_CRLF;
                  end else begin
                     line_chars_in = 5'd0;
                     syntax_in     = SY_WS;
                     size_accum_in = 14'd0;
                     ovf_in        = 1'b0;
                     crlf_bad_in   = 1'b0;
                     phase_in      = PH_SIZE;
                  end
               end
               PH_TRAILER: begin
                  if (rx_byte == CHAR_CR) begin
                     phase_in = PH_TRAILER;
                  end else if (rx_byte == CHAR_LF) begin
                     if (line_chars_ff != 5'd0) begin
                        line_chars_in = 5'd0;
                     end else if (delivered_ff != 10'd0) begin
                        success_in = 1'b1;
                        err_in     = ERR_NONE;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_DONE;
                        err_in   = ERR_EMPTY_BODY;
                     end
                  end else if (line_chars_ff >= line_max_ff) begin
                     phase_in = PH_DONE;
                     err_in   = ERR_TRAILER_LONG;
                  end else begin
                     line_chars_in = line_chars_ff + 5'd1;
                  end
               end
               PH_DONE: phase_in = PH_DONE;
               default: phase_in = PH_DONE;
            endcase
         end
      end

      result.payload_valid     = pv;
      result.data.payload_byte = pb;
      result.data.truncated    = trunc_in;
      result.data.finished     = (phase_in == PH_DONE);
      result.data.success      = success_in;
      result.data.error_code   = err_in;
      result.data.body_count   = delivered_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         syntax_ff     <= SY_WS;
         line_chars_ff <= 5'd0;
         size_accum_ff <= 14'd0;
         remaining_ff  <= 14'd0;
         total_ff      <= 14'd0;
         delivered_ff  <= 10'd0;
         trunc_ff      <= 1'b0;
         success_ff    <= 1'b0;
         ovf_ff        <= 1'b0;
         crlf_bad_ff   <= 1'b0;
         err_ff        <= ERR_NONE;
      end else begin
         phase_ff      <= phase_in;
         syntax_ff     <= syntax_in;
         line_chars_ff <= line_chars_in;
         size_accum_ff <= size_accum_in;
         remaining_ff  <= remaining_in;
         total_ff      <= total_in;
         delivered_ff  <= delivered_in;
         trunc_ff      <= trunc_in;
         success_ff    <= success_in;
         ovf_ff        <= ovf_in;
         crlf_bad_ff   <= crlf_bad_in;
         err_ff        <= err_in;
      end
   end

endmodule

>>> rtl/hcbd_rsp_buf.sv
// Result register with a skid stage for the decoder's output channel.
// Depends on hcbd_pkg for the result type.
module hcbd_rsp_buf
   import hcbd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  hcbd_result_type in_result,
   output logic            in_ready,
   output logic            out_valid,
   output hcbd_result_type out_result,
   input  logic            out_ready
);

   logic            head_valid_ff;
   logic            skid_valid_ff;
   hcbd_result_type head_ff;
   hcbd_result_type skid_ff;
   logic            head_free;

   assign head_free  = !head_valid_ff || out_ready;
   assign in_ready   = !skid_valid_ff;
   assign out_valid  = head_valid_ff;
   assign out_result = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (head_free) begin
            head_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (in_valid) begin
         if (head_free) begin
            head_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_ready) begin
         head_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (head_free) begin
            head_ff <= skid_ff;
         end
      end else if (in_valid) begin
         if (head_free) begin
            head_ff <= in_result;
         end else begin
            skid_ff <= in_result;
         end
      end
   end

endmodule

>>> rtl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder: byte stream in, status stream out.
// Depends on hcbd_pkg, hcbd_core, hcbd_rsp_buf and assert_macros.svh.
//
//   channel  direction  ports                 contents
//   req      in         req_tvalid/tready     tdata: rx_byte; tuser: action (1 = abort)
//   rsp      out        rsp_tvalid/tready     tdata: status word; tuser: payload_valid
//   csr      in         csr_we/index/wdata    total_limit, body_limit, line_max
//
// Every accepted beat produces exactly one result beat, registered in the result
// register or the skid entry; the decode state updates on each accepted beat.
// One beat per cycle is sustained while the skid entry is empty. A result register
// plus one skid entry decouple the sides, so a stalled consumer drops req_tready
// only once both are full. Synchronous active-high reset restores the register
// defaults and clears all decode state; no clearing pass is needed.
`include "assert_macros.svh"

module http_chunked_body_decoder
   import hcbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] action
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] payload_byte, [8] truncated, [9] finished,
                                    // [10] success, [13:11] error_code, [23:14] body_count
   output logic        rsp_tuser,   // [0] payload_valid
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   logic            req_accept;
   hcbd_result_type core_result;
   hcbd_result_type rsp_result;

   // A beat is taken whenever the skid entry is empty.
   assign req_accept = req_tvalid && req_tready;

   // The core updates the decode state on every accepted beat and presents
   // the status that the beat leaves behind.
   hcbd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (req_accept),
      .action    (req_tuser),
      .rx_byte   (req_tdata),
      .result    (core_result)
   );

   hcbd_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_accept),
      .in_result  (core_result),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_result (rsp_result),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = rsp_result.data;
   assign rsp_tuser = rsp_result.payload_valid;

   // Back-pressure only comes from a full skid entry, which needs a held result.
   `ASSERT_IMPLIES(a_stall_has_head, clock, reset, !req_tready, rsp_tvalid, "stall without a held result")
   // Payload bytes come only from the data phase, which never finishes decoding.
   `ASSERT_IMPLIES(a_payload_not_final, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tdata[9], "payload on a final status")
   // Success always comes with a finished status and no error code.
   `ASSERT_IMPLIES(a_success_clean, clock, reset, rsp_tvalid && rsp_tdata[10], rsp_tdata[9] && (rsp_tdata[13:11] == ERR_NONE), "success with error or unfinished")

endmodule

>>> dv/hcbd_status_checker.sv
// Status checker for the chunked body decoder: watches the req, rsp and csr ports,
// predicts one status beat per accepted byte and compares it with the rsp stream.
// Depends on hcbd_pkg for the result layout, the register indexes and the codes.
module hcbd_status_checker
   import hcbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata,
   output int          error_total,
   output int          status_backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   // Register copies.
   logic [13:0] lim_total;
   logic [9:0]  lim_body;
   logic [4:0]  lim_line;

   // Decoder state as the checker sees it.
   hcbd_phase_type  st_phase;
   hcbd_syntax_type st_syntax;
   logic [4:0]      st_line;
   logic [13:0]     st_acc;
   logic [13:0]     st_left;
   logic [13:0]     st_total;
   logic [9:0]      st_sent;
   logic            fl_trunc;
   logic            fl_ok;
   logic            fl_ovf;
   logic            fl_crlf;
   hcbd_err_type    st_err;

   hcbd_result_type expected_status [$];
   int              errors = 0;

   function automatic int hex_digit(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
      return -1;
   endfunction

   task automatic finish_with(hcbd_err_type code);
      st_phase = PH_DONE;
      st_err   = code;
   endtask

   task automatic start_line();
      st_line   = '0;
      st_syntax = SY_WS;
      st_acc    = '0;
      fl_ovf    = 1'b0;
      fl_crlf   = 1'b0;
   endtask

   // The size accumulator saturates and stays saturated for the rest of the line.
   task automatic shift_in(int d);
      int v;
      v = int'(st_acc) * 16 + d;
      if (fl_ovf || v > int'(ACC_MAX)) begin
         st_acc = ACC_MAX;
         fl_ovf = 1'b1;
      end else begin
         st_acc = v[13:0];
      end
   endtask

   task automatic decode_byte(input logic abort, input logic [7:0] b,
                              output hcbd_result_type res);
      int         d;
      logic       stop;
      logic       blank;
      logic       pv;
      logic [7:0] pb;
      d     = hex_digit(b);
      stop  = (b == CHAR_SEMI) || (b == CHAR_NUL);
      blank = (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C);
      pv    = 1'b0;
      pb    = 8'h00;
      if (st_phase != PH_DONE) begin
         if (abort) begin
            finish_with(ERR_ABORT);
         end else begin
            case (st_phase)
               PH_SIZE: begin
                  if (b == CHAR_LF) begin
                     if (st_syntax != SY_ZERO && st_syntax != SY_DIGITS && st_syntax != SY_OK) begin
                        finish_with(ERR_BAD_SIZE);
                     end else if (st_acc == 0 && !fl_ovf) begin
                        st_line  = '0;
                        st_phase = PH_TRAILER;
                     end else if (fl_ovf || int'(st_total) + int'(st_acc) > int'(lim_total)) begin
                        finish_with(ERR_OVER_LIMIT);
                     end else begin
                        st_total = st_total + st_acc;
                        st_left  = st_acc;
                        st_phase = PH_DATA;
                     end
                  end else if (b != CHAR_CR) begin
                     if (st_line >= lim_line) begin
                        finish_with(ERR_LINE_LONG);
                     end else begin
                        st_line++;
                        case (st_syntax)
                           SY_WS: begin
                              if (!blank) begin
                                 if (b == 8'h30) st_syntax = SY_ZERO;
                                 else if (d >= 0) begin
                                    shift_in(d);
                                    st_syntax = SY_DIGITS;
                                 end else st_syntax = SY_BAD;
                              end
                           end
                           SY_ZERO: begin
                              if (b == 8'h78 || b == 8'h58) st_syntax = SY_PREFIX;
                              else if (stop) st_syntax = SY_OK;
                              else if (d >= 0) begin
                                 shift_in(d);
                                 st_syntax = SY_DIGITS;
                              end else st_syntax = SY_BAD;
                           end
                           SY_PREFIX: begin
                              if (d >= 0) begin
                                 shift_in(d);
                                 st_syntax = SY_DIGITS;
                              end else st_syntax = SY_BAD;
                           end
                           SY_DIGITS: begin
                              if (d >= 0) shift_in(d);
                              else if (stop) st_syntax = SY_OK;
                              else st_syntax = SY_BAD;
                           end
                           default: ;
                        endcase
                     end
                  end
               end
               PH_DATA: begin
                  if (st_sent < lim_body) begin
                     st_sent++;
                     pv = 1'b1;
                     pb = b;
                  end else begin
                     fl_trunc = 1'b1;
                  end
                  if (st_left != 0) st_left--;
                  if (st_left == 0) begin
                     fl_crlf  = 1'b0;
                     st_phase = PH_CR;
                  end
               end
               PH_CR: begin
                  if (b != CHAR_CR) fl_crlf = 1'b1;
                  st_phase = PH_LF;
               end
               PH_LF: begin
                  if (fl_crlf || b != CHAR_LF) begin
                     finish_with(ERR_NO_CRLF);
                  end else begin
                     start_line();
                     st_phase = PH_SIZE;
                  end
               end
               PH_TRAILER: begin
                  if (b == CHAR_LF) begin
                     if (st_line != 0) st_line = '0;
                     else if (st_sent != 0) begin
                        fl_ok    = 1'b1;
                        st_phase = PH_DONE;
                        st_err   = ERR_NONE;
                     end else finish_with(ERR_EMPTY_BODY);
                  end else if (b != CHAR_CR) begin
                     if (st_line >= lim_line) finish_with(ERR_TRAILER_LONG);
                     else st_line++;
                  end
               end
               default: st_phase = PH_DONE;
            endcase
         end
      end
      res.payload_valid     = pv;
      res.data.payload_byte = pb;
      res.data.truncated    = fl_trunc;
      res.data.finished     = (st_phase == PH_DONE);
      res.data.success      = fl_ok;
      res.data.error_code   = st_err;
      res.data.body_count   = st_sent;
   endtask

   task automatic check_field(string label, logic [9:0] want, logic [9:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      hcbd_result_type want;
      hcbd_result_type got;
      if (reset) begin
         lim_total = TOTAL_LIMIT_RST;
         lim_body  = BODY_LIMIT_RST;
         lim_line  = LINE_MAX_RST;
         st_phase  = PH_SIZE;
         start_line();
         st_left   = '0;
         st_total  = '0;
         st_sent   = '0;
         fl_trunc  = 1'b0;
         fl_ok     = 1'b0;
         st_err    = ERR_NONE;
         expected_status.delete();
         errors = 0;
      end else begin
         // A status beat always trails its byte, so the rsp side is served first.
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_status.size() == 0) begin
               $display("%0t: status beat with nothing expected, actual %h", $time, got);
               errors++;
            end else begin
               want = expected_status.pop_front();
               check_field("payload_valid", 10'(want.payload_valid),
                           10'(got.payload_valid));
               check_field("payload_byte", 10'(want.data.payload_byte),
                           10'(got.data.payload_byte));
               check_field("truncated", 10'(want.data.truncated),
                           10'(got.data.truncated));
               check_field("finished", 10'(want.data.finished),
                           10'(got.data.finished));
               check_field("success", 10'(want.data.success),
                           10'(got.data.success));
               check_field("error_code", 10'(want.data.error_code),
                           10'(got.data.error_code));
               check_field("body_count", want.data.body_count, got.data.body_count);
            end
         end
         if (csr_we) begin
            case (hcbd_csr_type'(csr_index))
               CSR_TOTAL_LIMIT: lim_total = csr_wdata;
               CSR_BODY_LIMIT:  lim_body  = csr_wdata[9:0];
               CSR_LINE_MAX:    lim_line  = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tuser, req_tdata, want);
            expected_status.push_back(want);
         end
      end
      error_total    <= errors;
      status_backlog <= expected_status.size();
   end

endmodule

>>> dv/testbench.sv
// Top of the chunked body decoder testbench: clock, reset, byte stimulus,
// register writes and the verdict. Depends on hcbd_pkg, the decoder RTL and
// hcbd_status_checker, which does all prediction and comparison.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hcbd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   // Printable characters used to build size lines.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X_LOW = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;

   // How this run's body ends. The decoder only accepts one body per reset,
   // and reset is applied once, so every run walks one long well-formed body
   // and then closes it in one of these ways, picked by the seed.
   typedef enum int {
      END_SUCCESS,
      END_ABORT,
      END_LINE_LONG,
      END_BAD_SIZE,
      END_OVER_LIMIT,
      END_NO_CRLF,
      END_TRAILER_LONG,
      END_EMPTY,
      END_LINE_ZERO
   } body_end_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = CSR_TOTAL_LIMIT;
   logic [13:0] csr_wdata  = '0;

   int error_total;
   int status_backlog;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_sent     = 0;
   int total_sent     = 0;
   int cur_line_max   = 31;
   int cycle_count    = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   http_chunked_body_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   hcbd_status_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_total    (error_total),
      .status_backlog (status_backlog)
   );

   // The receiver stalls at random with the probability of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Hard stop in case the block hangs or a status beat never comes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Offers one beat, with a random gap before it, and returns at the edge that
   // accepts it. Valid is left high so back-to-back beats need no extra edge.
   task automatic send_beat(input logic abort, input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= abort;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_str(string s);
      for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
   endtask

   task automatic send_crlf();
      send_beat(1'b0, CHAR_CR);
      send_beat(1'b0, CHAR_LF);
   endtask

   // Any byte that counts toward a line's length.
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR || c == CHAR_LF);
      return c;
   endfunction

   function automatic logic [7:0] hex_char(int nib);
      if (nib < 10) return 8'(CHAR_ZERO + nib);
      return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 10);
   endfunction

   // Stops offering beats and waits until every status beat has come back.
   // The backlog count is registered in the checker, so the task waits on the clock
   // before it trusts the count.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (status_backlog != 0) @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges; csr_we stays high across
   // them so it never gets two assignments in one step.
   task automatic set_limits(logic [13:0] tot, logic [9:0] body, logic [4:0] line);
      csr_we    <= 1'b1;
      csr_index <= CSR_TOTAL_LIMIT;
      csr_wdata <= tot;
      @(posedge clock);
      csr_index <= CSR_BODY_LIMIT;
      csr_wdata <= 14'(body);
      @(posedge clock);
      csr_index <= CSR_LINE_MAX;
      csr_wdata <= 14'(line);
      @(posedge clock);
      csr_we <= 1'b0;
      cur_line_max = line;
   endtask

   // Sends a valid size line for the given size in a random spelling: leading
   // blanks, an optional 0x or 0X prefix or leading zeros, mixed-case digits,
   // an optional extension after a semicolon or NUL, and stray CR bytes. If
   // that would not fit in line_max the bare digits are sent instead.
   task automatic send_size_line(int size);
      logic [7:0] blanks [4] = '{8'h20, 8'h09, 8'h0B, 8'h0C};
      logic [7:0] digits [$];
      logic [7:0] text [$];
      int         rest;
      rest = size;
      do begin
         digits.push_front(hex_char(rest % 16));
         rest = rest / 16;
      end while (rest != 0);
      repeat ($urandom_range(0, 2)) text.push_back(blanks[$urandom_range(0, 3)]);
      case ($urandom_range(0, 3))
         1: begin
            text.push_back(CHAR_ZERO);
            text.push_back($urandom_range(0, 1) ? CHAR_X_LOW : CHAR_X_UP);
         end
         2: repeat ($urandom_range(1, 3)) text.push_back(CHAR_ZERO);
         default: ;
      endcase
      text = {text, digits};
      if ($urandom_range(0, 2) == 0) begin
         text.push_back($urandom_range(0, 1) ? CHAR_SEMI : CHAR_NUL);
         repeat ($urandom_range(0, 5)) text.push_back(plain_byte());
      end
      if (text.size() > cur_line_max) text = digits;
      foreach (text[i]) begin
         if ($urandom_range(0, 9) == 0) send_beat(1'b0, CHAR_CR);
         send_beat(1'b0, text[i]);
      end
      if ($urandom_range(0, 3) != 0) send_beat(1'b0, CHAR_CR);
      send_beat(1'b0, CHAR_LF);
   endtask

   // One complete chunk: size line, random payload, closing CR LF.
   task automatic send_chunk(int size);
      send_size_line(size);
      repeat (size) send_beat(1'b0, 8'($urandom_range(0, 255)));
      send_crlf();
      total_sent += size;
   endtask

   task automatic fill_chunks(int upto);
      while (items_sent < upto) begin
         send_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8));
      end
   endtask

   // A new idling pattern and register setting, applied only once the block
   // has returned every status beat.
   task automatic run_phase(int snd, int rcv, int upto, logic [13:0] tot,
                            logic [9:0] body, logic [4:0] line);
      wait_idle();
      send_idle_pct  = snd;
      recv_stall_pct = rcv;
      set_limits(tot, body, line);
      fill_chunks(upto);
   endtask

   initial begin
      body_end_type finale;
      logic         no_body;
      int           variant;
      logic [7:0]   wrong;
      logic [13:0]  end_total;
      string        zero_lines [5] = '{"0", "000", "0;end", " 0x0", "0X00"};
      string        bad_lines [6]  = '{"+1", "-2", "1 ", "0x", "", "g7"};

      finale  = body_end_type'($urandom_range(0, 8));
      variant = $urandom_range(0, 3);
      // For the empty-body ending nothing may ever be delivered.
      no_body = (finale == END_EMPTY);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver stalls heavily.
      send_idle_pct  = 21;
      recv_stall_pct = 71;

      // Tightest limits: a one-character size line and a one-byte total.
      set_limits(14'd1, no_body ? 10'd0 : 10'd1023, 5'd1);
      send_str("1");
      send_crlf();
      send_beat(1'b0, 8'hFF);
      send_crlf();
      total_sent = 1;

      // Every kind of leading blank, an uppercase prefix, and an extension
      // cut off by a semicolon and then a NUL.
      wait_idle();
      set_limits(14'd16383, no_body ? 10'd0 : 10'd1023, 5'd31);
      send_beat(1'b0, 8'h20);
      send_beat(1'b0, 8'h09);
      send_beat(1'b0, 8'h0B);
      send_beat(1'b0, 8'h0C);
      send_str("0X2");
      send_beat(1'b0, CHAR_SEMI);
      send_beat(1'b0, CHAR_NUL);
      send_str("q");
      send_crlf();
      send_beat(1'b0, 8'h00);
      send_beat(1'b0, 8'hFF);
      send_crlf();
      total_sent += 2;
      fill_chunks(650);

      // Sender idles heavily, receiver stalls lightly; random body and line caps.
      run_phase(71, 21, 1280, 14'd16383,
                no_body ? 10'd0 : 10'($urandom_range(0, 1023)),
                5'($urandom_range(4, 30)));

      // Full rate both ways; body_limit 0 turns every further byte into a drop.
      run_phase(0, 0, 1900, 14'd16383, 10'd0, 5'd31);

      // Registers for the closing sequence.
      end_total = 14'd16383;
      if (finale == END_OVER_LIMIT && variant == 2) end_total = 14'd0;
      if (finale == END_OVER_LIMIT && variant == 3) end_total = 14'(total_sent);
      wait_idle();
      set_limits(end_total, no_body ? 10'd0 : 10'($urandom_range(1, 1023)),
                 (finale == END_LINE_ZERO) ? 5'd0 : 5'd31);

      case (finale)
         END_SUCCESS, END_EMPTY: begin
            // Final zero-size chunk, a few trailer lines, then the empty line.
            send_str(zero_lines[$urandom_range(0, 4)]);
            if ($urandom_range(0, 1) != 0) send_beat(1'b0, CHAR_CR);
            send_beat(1'b0, CHAR_LF);
            repeat ($urandom_range(0, 3)) begin
               repeat ($urandom_range(1, cur_line_max)) send_beat(1'b0, plain_byte());
               if ($urandom_range(0, 1) != 0) send_beat(1'b0, CHAR_CR);
               send_beat(1'b0, CHAR_LF);
            end
            if ($urandom_range(0, 1) != 0) send_beat(1'b0, CHAR_CR);
            send_beat(1'b0, CHAR_LF);
         end
         END_ABORT: begin
            // Abort while in a size line, in data, before the CR, or in trailers.
            case (variant)
               0: send_str("1");
               1: begin
                  send_size_line(3);
                  repeat (2) send_beat(1'b0, 8'($urandom_range(0, 255)));
               end
               2: begin
                  send_size_line(1);
                  send_beat(1'b0, 8'($urandom_range(0, 255)));
               end
               default: begin
                  send_str("0");
                  send_beat(1'b0, CHAR_LF);
               end
            endcase
            send_beat(1'b1, 8'($urandom_range(0, 255)));
         end
         END_LINE_LONG: begin
            repeat (cur_line_max + 1) send_beat(1'b0, plain_byte());
         end
         END_BAD_SIZE: begin
            send_str(bad_lines[$urandom_range(0, 5)]);
            if ($urandom_range(0, 1) != 0) send_beat(1'b0, CHAR_CR);
            send_beat(1'b0, CHAR_LF);
         end
         END_OVER_LIMIT: begin
            // Saturating sizes, or a small size against a limit already used up.
            case (variant)
               0: send_str("4000");
               1: send_str("fffff;x");
               default: send_str("2");
            endcase
            send_beat(1'b0, CHAR_LF);
         end
         END_NO_CRLF: begin
            send_chunk_body: begin
               int n;
               n = $urandom_range(1, 4);
               send_size_line(n);
               repeat (n) send_beat(1'b0, 8'($urandom_range(0, 255)));
            end
            if (variant[0]) begin
               do wrong = 8'($urandom_range(0, 255)); while (wrong == CHAR_CR);
               send_beat(1'b0, wrong);
               send_beat(1'b0, 8'($urandom_range(0, 255)));
            end else begin
               do wrong = 8'($urandom_range(0, 255)); while (wrong == CHAR_LF);
               send_beat(1'b0, CHAR_CR);
               send_beat(1'b0, wrong);
            end
         end
         END_TRAILER_LONG: begin
            send_str("0");
            send_beat(1'b0, CHAR_LF);
            repeat (cur_line_max + 1) send_beat(1'b0, plain_byte());
         end
         default: begin
            // line_max is 0 here: the CR is dropped, the next byte is too many.
            send_beat(1'b0, CHAR_CR);
            send_beat(1'b0, plain_byte());
         end
      endcase

      // Once finished the block ignores input and repeats its final status.
      repeat (24) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

      wait_idle();
      // More edges are let pass to catch any stray status beat.
      repeat (8) @(posedge clock);
      if (error_total == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/hcbd_pkg.sv
rtl/hcbd_core.sv
rtl/hcbd_rsp_buf.sv
rtl/http_chunked_body_decoder.sv
dv/hcbd_status_checker.sv
dv/testbench.sv
